@@ hdl/sine_tone_mixer_normalizer_macros.svh @@
// Assertion macros for the sine tone mixer and normalizer.
`ifndef SINE_TONE_MIXER_NORMALIZER_MACROS_SVH
`define SINE_TONE_MIXER_NORMALIZER_MACROS_SVH

// Check cons in the same cycle as ante.
`define STMN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define STMN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/stmn_pkg.sv @@
// Shared types and constants for the sine tone mixer and normalizer.
package stmn_pkg;

  localparam int DEF_BUFFER_DEPTH     = 65536;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  localparam int SAMPLE_W = 24;
  localparam int PEAK_W   = 23;
  localparam int IDX_W    = 21;
  localparam int ROM_W    = 16;

  localparam logic [PEAK_W-1:0] ONE_Q15    = PEAK_W'(32768);
  localparam logic [63:0]       HALFPI_Q30 = 64'd1686629713;

  localparam int DIV_STEPS = 39;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_SCAN,
    REQ_READ,
    REQ_NONE
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/stmn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stmn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

@@ hdl/sine_tone_mixer_normalizer.sv @@
// Top level of the sine tone mixer and normalizer.
//
// One request channel: a beat is taken at a rising edge with start high and
// busy low. req_type selects add tone, peak scan or normalized read; the
// other request fields are sampled with the beat.
// One result channel: done is high for exactly one cycle per request, with
// sample_out, peak_out, clipped and saturated valid in that cycle. The
// receiver cannot stall; busy drops in the cycle done is high, so the next
// request may be taken in that cycle.
// Request kinds:
//   add tone:  one store read-modify-write per cycle over the samples in range
//   peak scan: one store read per cycle over the whole store
//   read:      bit-serial restoring divider
//   unknown:   no work, only done
// The sample store is one RAM with a single write and a single read port;
// a tone add runs a three-stage read, sine lookup, add and write pipeline.
// After reset the block clears the store one entry per cycle with busy high,
// and sets the peak to 1.0.
module sine_tone_mixer_normalizer
  import stmn_pkg::*;
#(
  parameter int BUFFER_DEPTH     = DEF_BUFFER_DEPTH,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [1:0]         req_type,
  input  logic [31:0]        phase_step,
  input  logic [19:0]        start_offset,
  input  logic [19:0]        tone_length,
  input  logic [15:0]        read_index,
  output logic signed [15:0] sample_out,
  output logic [22:0]        peak_out,
  output logic               clipped,
  output logic               saturated
);

`include "sine_tone_mixer_normalizer_macros.svh"

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int TW = $clog2(SINE_TABLE_DEPTH);
  localparam int IW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_L   = IDX_W'(BUFFER_DEPTH);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BUFFER_DEPTH - 1);
  localparam logic [47:0]      QUAD_SPAN = 48'(4 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0]    Q1_BASE   = IW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0]    Q2_BASE   = IW'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0]    Q3_BASE   = IW'(3 * SINE_TABLE_DEPTH);
  localparam logic [TW:0]      TAB_D     = (TW+1)'(SINE_TABLE_DEPTH);

  function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] a;
    a = (t * x) >> 30;
    return (a * x) >> 30;
  endfunction

  function automatic logic [ROM_W-1:0] rom_entry(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x = (HALFPI_Q30 * k) / SINE_TABLE_DEPTH;
    sum = signed'(x);
    term = sq_step(x, x) / 6;
    sum = sum - signed'(term);
    term = sq_step(term, x) / 20;
    sum = sum + signed'(term);
    term = sq_step(term, x) / 42;
    sum = sum - signed'(term);
    term = sq_step(term, x) / 72;
    sum = sum + signed'(term);
    term = sq_step(term, x) / 110;
    sum = sum - signed'(term);
    term = sq_step(term, x) / 156;
    sum = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = unsigned'(sum) + 64'd16384;
    return ROM_W'(r >> 15);
  endfunction

  logic [ROM_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = rom_entry(64'(k));
  end

  state_t state, state_next;

  logic [AW-1:0]       clr_addr;
  logic                mode_add;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    end_c;
  logic [31:0]         step_r;
  logic [31:0]         phase;
  logic [PEAK_W-1:0]   best;
  logic [PEAK_W-1:0]   peak;
  logic                sat_acc;

  logic                p1_valid;
  logic [AW-1:0]       p1_addr;
  logic [IW-1:0]       p1_idx;
  logic                p2_valid;
  logic [AW-1:0]       p2_addr;
  logic [SAMPLE_W-1:0] p2_data;
  logic [ROM_W-1:0]    rom_q;
  logic                p2_neg;
  logic                p2_one;

  logic [AW-1:0]       rd_addr_r;
  logic                rd_ok;
  logic                rd_neg;
  logic [38:0]         dvd;
  logic [PEAK_W-1:0]   rem;
  logic [SAMPLE_W-1:0] quo;
  logic [CNT_W-1:0]    cnt;

  logic                ram_we;
  logic [AW-1:0]       ram_wa;
  logic [SAMPLE_W-1:0] ram_wd;
  logic [AW-1:0]       ram_ra;
  logic [SAMPLE_W-1:0] ram_q;

  logic                accept;
  logic                issue;
  logic                walk_end;
  logic [47:0]         phase_prod;
  logic [IW-1:0]       pos;
  logic                quad_odd;
  logic                quad_neg;
  logic [TW-1:0]       rom_addr;
  logic                mirror_one;
  logic signed [17:0]  sine_val;
  logic signed [24:0]  sum_raw;
  logic [SAMPLE_W-1:0] sum_sat;
  logic                sum_ovf;
  logic [IDX_W-1:0]    tone_end;
  logic [SAMPLE_W-1:0] rd_x;
  logic [SAMPLE_W-1:0] rd_mag;
  logic [PEAK_W:0]     trial;
  logic                trial_ge;
  logic                clip_q;
  logic [15:0]         sample_q;

  stmn_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk(clk),
    .we (ram_we),
    .wa (ram_wa),
    .wd (ram_wd),
    .ra (ram_ra),
    .rd (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    ram_we     = p2_valid;
    ram_wa     = p2_addr;
    ram_wd     = sum_sat;
    ram_ra     = rd_addr_r;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_addr;
        ram_wd = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          unique case (req_t'(req_type))
            REQ_ADD, REQ_SCAN: state_next = ST_WALK;
            REQ_READ:          state_next = ST_RD_ADDR;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        ram_ra = cur[AW-1:0];
        if (walk_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign accept   = start && !busy;
  assign issue    = (state == ST_WALK) && (cur < end_c);
  assign walk_end = (state == ST_WALK) && !issue && !p1_valid && !p2_valid;
  assign tone_end = IDX_W'(start_offset) + IDX_W'(tone_length);

  // Sine wave index of the phase being issued.
  assign phase_prod = 48'(phase) * QUAD_SPAN;

  always_comb begin
    quad_odd = 1'b0;
    quad_neg = 1'b0;
    pos      = p1_idx;
    if (p1_idx >= Q3_BASE) begin
      quad_odd = 1'b1;
      quad_neg = 1'b1;
      pos      = p1_idx - Q3_BASE;
    end else if (p1_idx >= Q2_BASE) begin
      quad_neg = 1'b1;
      pos      = p1_idx - Q2_BASE;
    end else if (p1_idx >= Q1_BASE) begin
      quad_odd = 1'b1;
      pos      = p1_idx - Q1_BASE;
    end
    mirror_one = quad_odd && (pos == '0);
    if (quad_odd) begin
      rom_addr = TW'(TAB_D - (TW+1)'(pos));
    end else begin
      rom_addr = TW'(pos);
    end
  end

  always_comb begin
    sine_val = p2_one ? 18'sd32768 : signed'({2'b00, rom_q});
    if (p2_neg) begin
      sine_val = -sine_val;
    end
    sum_raw = 25'(signed'(p2_data)) + 25'(sine_val);
    sum_ovf = 1'b0;
    sum_sat = sum_raw[SAMPLE_W-1:0];
    if (sum_raw > 25'sd8388607) begin
      sum_sat = 24'h7FFFFF;
      sum_ovf = 1'b1;
    end else if (sum_raw < -25'sd8388608) begin
      sum_sat = 24'h800000;
      sum_ovf = 1'b1;
    end
  end

  assign rd_x     = rd_ok ? ram_q : '0;
  assign rd_mag   = rd_x[SAMPLE_W-1] ? (~rd_x + 1'b1) : rd_x;
  assign trial    = {rem, dvd[38]};
  assign trial_ge = trial >= {1'b0, peak};

  always_comb begin
    clip_q = 1'b0;
    if (rd_neg) begin
      if (quo > SAMPLE_W'(32768)) begin
        clip_q   = 1'b1;
        sample_q = 16'h8000;
      end else begin
        sample_q = 16'(~quo + 1'b1);
      end
    end else begin
      if (quo > SAMPLE_W'(32767)) begin
        clip_q   = 1'b1;
        sample_q = 16'h7FFF;
      end else begin
        sample_q = 16'(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      peak     <= ONE_Q15;
      done     <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      done     <= walk_end || (state == ST_FINISH) ||
                  (accept && req_t'(req_type) == REQ_NONE);
      p1_valid <= issue;
      p2_valid <= p1_valid && mode_add;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (walk_end && !mode_add) begin
        peak <= best;
      end
    end

    // Capture the request.
    if (accept) begin
      mode_add   <= (req_t'(req_type) == REQ_ADD);
      step_r     <= phase_step;
      phase      <= 32'(phase_step * 52'(start_offset));
      best       <= ONE_Q15;
      sat_acc    <= 1'b0;
      rd_addr_r  <= AW'(read_index);
      rd_ok      <= IDX_W'(read_index) < DEPTH_L;
      sample_out <= '0;
      clipped    <= 1'b0;
      saturated  <= 1'b0;
      if (req_t'(req_type) == REQ_ADD) begin
        cur   <= IDX_W'(start_offset);
        end_c <= (tone_end > DEPTH_L) ? DEPTH_L : tone_end;
      end else begin
        cur   <= '0;
        end_c <= DEPTH_L;
      end
    end

    // Walk pipeline: issue, lookup, add and write back for a tone add; peak compare for a scan.
    if (issue) begin
      cur   <= cur + 1'b1;
      phase <= phase + step_r;
    end
    p1_addr <= cur[AW-1:0];
    p1_idx  <= IW'(phase_prod >> 32);
    p2_addr <= p1_addr;
    p2_data <= ram_q;
    rom_q   <= sine_rom[rom_addr];
    p2_neg  <= quad_neg;
    p2_one  <= mirror_one;
    if (p2_valid && sum_ovf) begin
      sat_acc <= 1'b1;
    end
    if (p1_valid && !mode_add && !ram_q[SAMPLE_W-1] && ram_q[PEAK_W-1:0] > best) begin
      best <= ram_q[PEAK_W-1:0];
    end
    if (walk_end) begin
      saturated <= sat_acc;
    end

    // Normalized read through the restoring divider.
    if (state == ST_RD_DATA) begin
      rd_neg <= rd_x[SAMPLE_W-1];
      dvd    <= {rd_mag, 15'b0};
      rem    <= '0;
      quo    <= '0;
      cnt    <= '0;
    end
    if (state == ST_DIV) begin
      dvd <= {dvd[37:0], 1'b0};
      cnt <= cnt + 1'b1;
      quo <= {quo[SAMPLE_W-2:0], trial_ge};
      if (trial_ge) begin
        rem <= PEAK_W'(trial - {1'b0, peak});
      end else begin
        rem <= PEAK_W'(trial);
      end
    end
    if (state == ST_FINISH) begin
      sample_out <= signed'(sample_q);
      clipped    <= clip_q;
    end
  end

  assign peak_out = peak;

  `STMN_ASSERT_SAME(a_done_not_busy, done, !busy, "result beat while busy")
  `STMN_ASSERT_SAME(a_scan_no_write, (state == ST_WALK) && !mode_add, !ram_we,
                    "store written during peak scan")
  `STMN_ASSERT_SAME(a_peak_floor, busy || !busy, peak >= ONE_Q15, "peak below 1.0")
  `STMN_ASSERT_NEXT(a_work_busy, start && !busy && (req_type != REQ_NONE), busy,
                    "request beat did not raise busy")
  `STMN_ASSERT_NEXT(a_pipe_order, p1_valid && mode_add, p2_valid,
                    "tone sample dropped between lookup and write")

endmodule
